[rtl/tfc_pkg.sv]
// ----------------------------------------------------------------------------
// tfc_pkg
// Shared types, constants and the byte-wide CRC-16 step for the frame checker.
// ----------------------------------------------------------------------------
package tfc_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned CRC_W    = 16;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned TEMP_W   = 14;
  localparam int unsigned LIMIT_W  = 8;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [IDX_W-1:0]  LAST_BYTE     = 4'd12;
  localparam logic [IDX_W-1:0]  CRC_LAST_BYTE = 4'd10;
  localparam logic [IDX_W-1:0]  LEN_LAST_BYTE = 4'd3;
  localparam logic [IDX_W-1:0]  ID_FIRST_BYTE = 4'd5;
  localparam logic [IDX_W-1:0]  ID_LAST_BYTE  = 4'd8;
  localparam logic [IDX_W-1:0]  READ_LO_BYTE  = 4'd9;
  localparam logic [IDX_W-1:0]  READ_HI_BYTE  = 4'd10;
  localparam logic [IDX_W-1:0]  CRC_LO_BYTE   = 4'd11;

  localparam logic [CRC_W-1:0]  CRC_INIT      = 16'hFFFF;
  localparam logic [CRC_W-1:0]  CRC_POLY      = 16'h1021;
  localparam logic [WORD_W-1:0] EXPECTED_LEN  = 32'd9;

  localparam logic signed [LIMIT_W-1:0] UPPER_RESET = 8'sd80;
  localparam logic signed [LIMIT_W-1:0] LOWER_RESET = -8'sd40;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UPPER = 1'b0,
    REG_LOWER = 1'b1
  } cfg_reg_t;

  // one byte held in the input register
  typedef struct packed {
    logic              vld;
    logic              start;
    logic [BYTE_W-1:0] data;
  } byte_stage_t;

  // crc-16/ccitt-false, msb first, one byte
  function automatic logic [CRC_W-1:0] crc_add_byte(input logic [CRC_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, {(CRC_W-BYTE_W){1'b0}}};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[rtl/temperature_frame_checker.sv]
// ----------------------------------------------------------------------------
// temperature_frame_checker
// Byte-serial sensor frame checker: CRC-16/CCITT-FALSE over the first eleven
// bytes, length and limit checks, one result per thirteen-byte frame.
// ----------------------------------------------------------------------------
//  channel  signals                                     handshake
//  in       in_frame_byte, in_frame_start               in_valid / in_stall
//  out      out_frame_ok, out_sensor_id,                out_valid / out_stall
//           out_temperature, out_out_of_range
//  cfg      cfg_index, cfg_data                         cfg_valid / cfg_ready
//
//  one byte per cycle sustained while no result waits under out_stall; a byte
//  is held in the input register until it passes the byte-wide crc/capture
//  logic, and out_valid is registered from the result of the last byte.
//  reset (rst_n low, synchronous) clears the byte position, both valid flags
//  and loads the limits with +80 and -40 degrees.
//  in_stall rises whenever a result waits in the output register under
//  out_stall, whether or not the input register holds a byte.
// ----------------------------------------------------------------------------
module temperature_frame_checker
  import tfc_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [BYTE_W-1:0]           in_frame_byte,
  input  logic                        in_frame_start,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_frame_ok,
  output logic [WORD_W-1:0]           out_sensor_id,
  output logic signed [TEMP_W-1:0]    out_temperature,
  output logic                        out_out_of_range,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic signed [LIMIT_W-1:0]   cfg_data
);

  logic signed [LIMIT_W-1:0] upper_r, upper_nxt;
  logic signed [LIMIT_W-1:0] lower_r, lower_nxt;
  logic                      advance;
  byte_stage_t               stage;

  assign cfg_ready = 1'b1;

  always_comb begin
    upper_nxt = upper_r;
    lower_nxt = lower_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_UPPER: upper_nxt = cfg_data;
        REG_LOWER: lower_nxt = cfg_data;
        default:   upper_nxt = upper_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r <= UPPER_RESET;
      lower_r <= LOWER_RESET;
    end else begin
      upper_r <= upper_nxt;
      lower_r <= lower_nxt;
    end
  end

  tfc_in_stage u_in_stage (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_frame_byte  (in_frame_byte),
    .in_frame_start (in_frame_start),
    .advance        (advance),
    .in_stall       (in_stall),
    .stage          (stage)
  );

  tfc_frame_core u_frame_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .stage            (stage),
    .upper_limit      (upper_r),
    .lower_limit      (lower_r),
    .out_stall        (out_stall),
    .advance          (advance),
    .out_valid        (out_valid),
    .out_frame_ok     (out_frame_ok),
    .out_sensor_id    (out_sensor_id),
    .out_temperature  (out_temperature),
    .out_out_of_range (out_out_of_range)
  );

endmodule

[rtl/tfc_in_stage.sv]
// ----------------------------------------------------------------------------
// tfc_in_stage
// Input register: captures one byte transaction and holds it until the
// frame core can move it on.
// ----------------------------------------------------------------------------
module tfc_in_stage
  import tfc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [BYTE_W-1:0] in_frame_byte,
  input  logic              in_frame_start,
  input  logic              advance,
  output logic              in_stall,
  output byte_stage_t       stage
);

  byte_stage_t stage_r;
  byte_stage_t stage_nxt;

  assign in_stall = !advance;

  always_comb begin
    stage_nxt = stage_r;
    if (advance) begin
      stage_nxt.vld   = in_valid;
      stage_nxt.start = in_frame_start;
      stage_nxt.data  = in_frame_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.vld <= 1'b0;
    end else begin
      stage_r.vld <= stage_nxt.vld;
    end
    stage_r.start <= stage_nxt.start;
    stage_r.data  <= stage_nxt.data;
  end

  assign stage = stage_r;

endmodule

[rtl/tfc_frame_core.sv]
// ----------------------------------------------------------------------------
// tfc_frame_core
// Byte position tracking, running CRC, field capture and the result register.
// ----------------------------------------------------------------------------
module tfc_frame_core
  import tfc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  byte_stage_t                stage,
  input  logic signed [LIMIT_W-1:0]  upper_limit,
  input  logic signed [LIMIT_W-1:0]  lower_limit,
  input  logic                       out_stall,
  output logic                       advance,
  output logic                       out_valid,
  output logic                       out_frame_ok,
  output logic [WORD_W-1:0]          out_sensor_id,
  output logic signed [TEMP_W-1:0]   out_temperature,
  output logic                       out_out_of_range
);

  logic [IDX_W-1:0]  byte_idx_r, byte_idx_nxt;
  logic [CRC_W-1:0]  crc_r, crc_nxt;
  logic [WORD_W-1:0] len_r, len_nxt;
  logic [WORD_W-1:0] id_r, id_nxt;
  logic [CRC_W-1:0]  reading_r, reading_nxt;
  logic [BYTE_W-1:0] rx_crc_lo_r, rx_crc_lo_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic                     frame_ok_r, frame_ok_nxt;
  logic [WORD_W-1:0]        sensor_id_r, sensor_id_nxt;
  logic signed [TEMP_W-1:0] temp_r, temp_nxt;
  logic                     oor_r, oor_nxt;

  logic [IDX_W-1:0]  idx;
  logic [CRC_W-1:0]  crc_base, len_base_dummy;
  logic [WORD_W-1:0] len_base, id_base;
  logic [CRC_W-1:0]  reading_base;
  logic [CRC_W-1:0]  crc_upd;
  logic [CRC_W-1:0]  rx_crc;
  logic              ok;
  logic signed [TEMP_W-1:0] t;
  logic signed [TEMP_W-1:0] hi;
  logic signed [TEMP_W-1:0] lo;
  logic              take;
  logic              last;

  // result register free or being drained this cycle
  assign advance = !out_valid_r || !out_stall;
  assign take    = advance && stage.vld;

  always_comb begin
    if (stage.start || byte_idx_r > LAST_BYTE) begin
      idx = '0;
    end else begin
      idx = byte_idx_r;
    end
  end

  assign last = (idx == LAST_BYTE);

  // a new frame starts from cleared fields
  assign crc_base       = (idx == '0) ? CRC_INIT : crc_r;
  assign len_base       = (idx == '0) ? '0 : len_r;
  assign id_base        = (idx == '0) ? '0 : id_r;
  assign reading_base   = (idx == '0) ? '0 : reading_r;
  assign len_base_dummy = crc_base;
  assign crc_upd        = crc_add_byte(len_base_dummy, stage.data);

  always_comb begin
    crc_nxt       = crc_r;
    len_nxt       = len_r;
    id_nxt        = id_r;
    reading_nxt   = reading_r;
    rx_crc_lo_nxt = rx_crc_lo_r;
    byte_idx_nxt  = byte_idx_r;
    if (take) begin
      len_nxt     = len_base;
      id_nxt      = id_base;
      reading_nxt = reading_base;
      if (idx == '0) begin
        rx_crc_lo_nxt = '0;
      end
      if (idx <= CRC_LAST_BYTE) begin
        crc_nxt = crc_upd;
      end else if (last) begin
        crc_nxt = CRC_INIT;
      end else begin
        crc_nxt = crc_base;
      end
      if (idx <= LEN_LAST_BYTE) begin
        len_nxt[{idx[1:0], 3'b000} +: BYTE_W] = stage.data;
      end else if (idx >= ID_FIRST_BYTE && idx <= ID_LAST_BYTE) begin
        id_nxt[{idx[1:0] - 2'd1, 3'b000} +: BYTE_W] = stage.data;
      end else if (idx == READ_LO_BYTE) begin
        reading_nxt[BYTE_W-1:0] = stage.data;
      end else if (idx == READ_HI_BYTE) begin
        reading_nxt[CRC_W-1:BYTE_W] = stage.data;
      end else if (idx == CRC_LO_BYTE) begin
        rx_crc_lo_nxt = stage.data;
      end
      byte_idx_nxt = last ? '0 : idx + 4'd1;
    end
  end

  // result of the last byte
  assign rx_crc = {stage.data, rx_crc_lo_r};
  assign ok     = (len_r == EXPECTED_LEN) && (rx_crc == crc_r);
  assign t      = reading_r[TEMP_W-1:0];
  assign hi     = {upper_limit, 6'b000000};
  assign lo     = {lower_limit, 6'b000000};

  always_comb begin
    out_valid_nxt = out_valid_r;
    frame_ok_nxt  = frame_ok_r;
    sensor_id_nxt = sensor_id_r;
    temp_nxt      = temp_r;
    oor_nxt       = oor_r;
    if (advance) begin
      out_valid_nxt = take && last;
      if (take && last) begin
        frame_ok_nxt  = ok;
        sensor_id_nxt = id_r;
        temp_nxt      = ok ? t : '0;
        oor_nxt       = ok && !((hi > t) && (t > lo));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      byte_idx_r  <= byte_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    crc_r       <= crc_nxt;
    len_r       <= len_nxt;
    id_r        <= id_nxt;
    reading_r   <= reading_nxt;
    rx_crc_lo_r <= rx_crc_lo_nxt;
    frame_ok_r  <= frame_ok_nxt;
    sensor_id_r <= sensor_id_nxt;
    temp_r      <= temp_nxt;
    oor_r       <= oor_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_frame_ok     = frame_ok_r;
  assign out_sensor_id    = sensor_id_r;
  assign out_temperature  = temp_r;
  assign out_out_of_range = oor_r;

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_idx_r <= LAST_BYTE)
    else $error("byte index past last byte");

  a_bad_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !frame_ok_r) |-> (temp_r == '0 && !oor_r))
    else $error("invalid frame carries temperature or range flag");

  a_wrap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (take && last) |=> (byte_idx_r == '0 && out_valid_r))
    else $error("last byte did not close the frame");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(sensor_id_r)))
    else $error("stalled result lost");

endmodule
